### sv/prr_pkg.sv
// Shared types, codes and helper functions for the page run reserver.
`timescale 1ns / 1ps

package prr_pkg;

    localparam int START_W        = 10;
    localparam int CNT_W          = 11;
    localparam int STATUS_W       = 2;
    localparam int ADDR_W         = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;
    localparam int WORD_W         = 32;
    localparam int BIT_SEL_W      = 5;
    localparam int WIDX_W         = CNT_W - BIT_SEL_W;
    localparam int NUM_PAGES_DEF  = 1024;
    localparam int PAGE_SHIFT_DEF = 12;

    typedef logic [START_W-1:0]   t_start;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [CNT_W:0]       t_sum;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [BIT_SEL_W-1:0] t_bsel;
    typedef logic [WIDX_W-1:0]    t_widx;

    localparam t_cnt PAGE_TOTAL_RST = t_cnt'(1024);

    localparam t_status STAT_OK       = 2'd0;
    localparam t_status STAT_REFUSED  = 2'd1;
    localparam t_status STAT_CONFLICT = 2'd2;

    localparam t_cfg_idx REG_REGION_BASE = 1'd0;
    localparam t_cfg_idx REG_PAGE_TOTAL  = 1'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;

    function automatic t_word run_mask(input t_bsel lo, input t_bsel hi);
        t_word m;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = (t_bsel'(b) >= lo) && (t_bsel'(b) <= hi);
        end
        return m;
    endfunction

    function automatic t_bsel first_one(input t_word w);
        t_bsel idx;
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w[b]) begin
                idx = t_bsel'(b);
            end
        end
        return idx;
    endfunction

endpackage

### sv/page_run_reserver.sv
// Top level of the page run reserver: reserved-page map in word RAM, scan and mark sequencer.
// Refused or empty runs go straight to the result; a run spanning W map words is scanned
// and, if no reserved page is hit, marked (one word per cycle to scan, one per cycle to mark).
// Requests are taken one at a time: the next input beat is taken only once the last result
// has been loaded into the output register, after the word-serial scan and mark.
// Reset: synchronous, active low; clears control state, then sweeps the map RAM to zero,
// one word per cycle over all ceil(NUM_PAGES/32) words, before the first input beat is taken.
`timescale 1ns / 1ps

module page_run_reserver #(
    parameter int NUM_PAGES  = prr_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = prr_pkg::PAGE_SHIFT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  prr_pkg::t_start    i_start_page,
    input  prr_pkg::t_cnt      i_page_count,
    output logic               o_valid,
    input  logic               i_ready,
    output prr_pkg::t_status   o_status,
    output prr_pkg::t_start    o_conflict_page,
    output prr_pkg::t_addr     o_page_address,
    output prr_pkg::t_cnt      o_pages_reserved,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  prr_pkg::t_cfg_idx  i_cfg_index,
    input  logic [prr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH  = (NUM_PAGES + prr_pkg::WORD_W - 1) / prr_pkg::WORD_W;
    localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef logic [RAM_AW-1:0] t_raddr;

    prr_pkg::t_state  r_state, n_state;
    prr_pkg::t_addr   r_region_base;
    prr_pkg::t_cnt    r_page_total;
    prr_pkg::t_cnt    r_count;
    prr_pkg::t_start  r_start;
    prr_pkg::t_cnt    r_cnt_req;
    prr_pkg::t_cnt    r_end_m1;
    prr_pkg::t_widx   r_rd_w;
    prr_pkg::t_widx   r_ck_w;
    logic             r_rd_on;
    logic             r_ck_on;
    t_raddr           r_clr;
    prr_pkg::t_status r_res_status;
    prr_pkg::t_start  r_res_conflict;
    prr_pkg::t_addr   r_res_addr;
    logic             r_o_valid;
    prr_pkg::t_status r_o_status;
    prr_pkg::t_start  r_o_conflict;
    prr_pkg::t_addr   r_o_addr;
    prr_pkg::t_cnt    r_o_reserved;

    prr_pkg::t_cnt    w_total;
    prr_pkg::t_cnt    w_free;
    prr_pkg::t_sum    w_sum;
    logic             w_refuse;
    logic             w_in_beat;
    logic             w_out_free;
    prr_pkg::t_widx   w_first_w;
    prr_pkg::t_widx   w_in_first_w;
    prr_pkg::t_widx   w_last_w;
    prr_pkg::t_bsel   w_lo;
    prr_pkg::t_bsel   w_hi;
    prr_pkg::t_word   w_mask;
    prr_pkg::t_word   w_rdata;
    prr_pkg::t_word   w_hits;
    logic             w_hit;
    logic             w_ck_last;
    logic             w_clr_last;

    logic             w_ram_we;
    t_raddr           w_ram_waddr;
    prr_pkg::t_word   w_ram_wdata;
    logic             w_ram_re;
    t_raddr           w_ram_raddr;

    // request checks, taken on the input beat
    always_comb begin
        w_total = (32'(r_page_total) > NUM_PAGES) ? prr_pkg::t_cnt'(NUM_PAGES) : r_page_total;
        w_free  = (r_count < w_total) ? (w_total - r_count) : '0;
        w_sum   = prr_pkg::t_sum'(i_start_page) + prr_pkg::t_sum'(i_page_count);
        w_refuse = (w_sum > prr_pkg::t_sum'(w_total)) || (i_page_count > w_free);
        w_in_first_w = prr_pkg::t_widx'(i_start_page[prr_pkg::START_W-1:prr_pkg::BIT_SEL_W]);
    end

    // word mask of the run and hit search on the word just read
    always_comb begin
        w_first_w = prr_pkg::t_widx'(r_start[prr_pkg::START_W-1:prr_pkg::BIT_SEL_W]);
        w_last_w  = r_end_m1[prr_pkg::CNT_W-1:prr_pkg::BIT_SEL_W];
        w_lo      = (r_ck_w == w_first_w) ? r_start[prr_pkg::BIT_SEL_W-1:0] : '0;
        w_hi      = (r_ck_w == w_last_w) ? r_end_m1[prr_pkg::BIT_SEL_W-1:0] : '1;
        w_mask    = prr_pkg::run_mask(w_lo, w_hi);
        w_hits    = w_rdata & w_mask;
        w_hit     = r_ck_on && (w_hits != '0);
        w_ck_last = r_ck_on && (r_ck_w == w_last_w);
        w_clr_last = (r_clr == t_raddr'(DEPTH - 1));
    end

    assign w_in_beat  = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prr_pkg::S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = prr_pkg::S_IDLE;
                end
            end
            prr_pkg::S_IDLE: begin
                if (w_in_beat) begin
                    if (w_refuse || (i_page_count == '0)) begin
                        n_state = prr_pkg::S_DONE;
                    end else begin
                        n_state = prr_pkg::S_SCAN;
                    end
                end
            end
            prr_pkg::S_SCAN: begin
                if (w_hit) begin
                    n_state = prr_pkg::S_DONE;
                end else if (w_ck_last) begin
                    n_state = prr_pkg::S_MARK;
                end
            end
            prr_pkg::S_MARK: begin
                if (w_ck_last) begin
                    n_state = prr_pkg::S_DONE;
                end
            end
            prr_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = prr_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = t_raddr'(r_ck_w);
        w_ram_wdata = w_rdata | w_mask;
        w_ram_re    = 1'b0;
        w_ram_raddr = t_raddr'(r_rd_w);
        unique case (r_state)
            prr_pkg::S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr;
                w_ram_wdata = '0;
            end
            prr_pkg::S_IDLE: begin
                o_ready = 1'b1;
            end
            prr_pkg::S_SCAN: begin
                w_ram_re = r_rd_on;
            end
            prr_pkg::S_MARK: begin
                w_ram_re = r_rd_on;
                w_ram_we = r_ck_on;
            end
            prr_pkg::S_DONE: begin
                o_ready = 1'b0;
            end
        endcase
    end

    prr_ram #(
        .WIDTH (prr_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= prr_pkg::S_CLEAR;
            r_region_base <= '0;
            r_page_total  <= prr_pkg::PAGE_TOTAL_RST;
            r_count       <= '0;
            r_rd_on       <= 1'b0;
            r_ck_on       <= 1'b0;
            r_clr         <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    prr_pkg::REG_REGION_BASE: r_region_base <= prr_pkg::t_addr'(i_cfg_data);
                    prr_pkg::REG_PAGE_TOTAL:  r_page_total  <= prr_pkg::t_cnt'(i_cfg_data);
                endcase
            end
            if (r_state == prr_pkg::S_CLEAR) begin
                r_clr <= r_clr + t_raddr'(1);
            end
            // read pipeline: issue one word per cycle, check it on the next
            if ((r_state == prr_pkg::S_IDLE) && w_in_beat) begin
                r_rd_on <= 1'b1;
                r_ck_on <= 1'b0;
            end else if ((r_state == prr_pkg::S_SCAN) && !w_hit && w_ck_last) begin
                r_rd_on <= 1'b1;
                r_ck_on <= 1'b0;
            end else if ((r_state == prr_pkg::S_SCAN) || (r_state == prr_pkg::S_MARK)) begin
                r_ck_on <= r_rd_on;
                if (r_rd_on && (r_rd_w == w_last_w)) begin
                    r_rd_on <= 1'b0;
                end
            end else begin
                r_ck_on <= 1'b0;
            end
            if ((r_state == prr_pkg::S_MARK) && w_ck_last) begin
                r_count <= r_count + r_cnt_req;
            end
            if ((r_state == prr_pkg::S_DONE) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            prr_pkg::S_IDLE: begin
                if (w_in_beat) begin
                    r_start        <= i_start_page;
                    r_cnt_req      <= i_page_count;
                    r_end_m1       <= prr_pkg::t_cnt'(w_sum - prr_pkg::t_sum'(1));
                    r_rd_w         <= w_in_first_w;
                    r_res_conflict <= i_start_page;
                    r_res_status   <= w_refuse ? prr_pkg::STAT_REFUSED : prr_pkg::STAT_OK;
                    if (prr_pkg::t_cnt'(i_start_page) < w_total) begin
                        r_res_addr <= r_region_base
                                    + (prr_pkg::t_addr'(i_start_page) << PAGE_SHIFT);
                    end else begin
                        r_res_addr <= '0;
                    end
                end
            end
            prr_pkg::S_SCAN: begin
                r_ck_w <= r_rd_w;
                if (w_hit) begin
                    r_res_status   <= prr_pkg::STAT_CONFLICT;
                    r_res_conflict <= prr_pkg::t_start'({r_ck_w, prr_pkg::first_one(w_hits)});
                end else if (w_ck_last) begin
                    r_rd_w <= w_first_w;
                end else if (r_rd_on) begin
                    r_rd_w <= r_rd_w + prr_pkg::t_widx'(1);
                end
            end
            prr_pkg::S_MARK: begin
                r_ck_w <= r_rd_w;
                if (r_rd_on) begin
                    r_rd_w <= r_rd_w + prr_pkg::t_widx'(1);
                end
            end
            prr_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_o_status   <= r_res_status;
                    r_o_conflict <= r_res_conflict;
                    r_o_addr     <= r_res_addr;
                    r_o_reserved <= r_count;
                end
            end
            prr_pkg::S_CLEAR: begin
                r_ck_w <= '0;
            end
        endcase
    end

    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_conflict_page  = r_o_conflict;
    assign o_page_address   = r_o_addr;
    assign o_pages_reserved = r_o_reserved;

endmodule

### sv/prr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module prr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/prr_checker.sv
// Port-level checks for the page run reserver, bound to the top level.
`timescale 1ns / 1ps

module prr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input prr_pkg::t_status  o_status,
    input prr_pkg::t_start   o_conflict_page,
    input prr_pkg::t_addr    o_page_address,
    input prr_pkg::t_cnt     o_pages_reserved
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_conflict_page)
            && $stable(o_page_address) && $stable(o_pages_reserved))
        else $error("result beat changed while stalled");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while a request is in progress");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid && i_ready) |-> o_pages_reserved >= $past(o_pages_reserved))
        else $error("reserved page count dropped");

    a_fail_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid && i_ready) && (o_status != prr_pkg::STAT_OK)
            |-> o_pages_reserved == $past(o_pages_reserved))
        else $error("refused or conflicting request changed the count");

endmodule

bind page_run_reserver prr_checker u_prr_checker (.*);
